// ===== sv/bbpll_pkg.sv =====
package bbpll_pkg;

  // accumulator and code geometry
  localparam int unsigned MAX_FRACTION_BITS = 20;
  localparam int unsigned CODE_W            = 10;
  localparam int unsigned OSC_W             = 8;
  localparam int unsigned ACC_W             = CODE_W + MAX_FRACTION_BITS;

  // register widths
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned KP_W    = 10;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned INIT_W  = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  // boosted gain can be shifted by the full shift field range
  localparam int unsigned KI_W  = GAIN_W + (1 << SHIFT_W) - 1;
  localparam int unsigned SUM_W = KI_W + 2;

  // stream payload widths
  localparam int unsigned DEC_W      = 2;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 24;

  // code limits
  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(1023);
  localparam logic [RUN_W-1:0]  RUN_MAX  = RUN_W'(255);

  // phase decision codes
  localparam logic [DEC_W-1:0] DEC_HOLD = 2'b00;
  localparam logic [DEC_W-1:0] DEC_UP   = 2'b01;

  // register indexes
  localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_FRACTION_BITS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOOST_SHIFT       = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOOST_RUN_LENGTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DECAY_SHIFT       = 3'd5;
  localparam logic [IDX_W-1:0] REG_INITIAL_CODE      = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN     = GAIN_W'(255);
  localparam logic [KP_W-1:0]    RST_PROPORTIONAL_GAIN = KP_W'(8);
  localparam logic [SHIFT_W-1:0] RST_FRACTION_BITS     = SHIFT_W'(6);
  localparam logic [SHIFT_W-1:0] RST_BOOST_SHIFT       = SHIFT_W'(4);
  localparam logic [RUN_W-1:0]   RST_BOOST_RUN_LENGTH  = RUN_W'(1);
  localparam logic [SHIFT_W-1:0] RST_DECAY_SHIFT       = SHIFT_W'(0);
  localparam logic [INIT_W-1:0]  RST_INITIAL_CODE      = INIT_W'(96);
  localparam logic [ACC_W-1:0]   RST_ACC = ACC_W'(96 * 4) << 6;

endpackage

// ===== sv/bang_bang_pll_loop_filter_top.sv =====
// channel   dir  width  fields (low bit up)
// s_axis    in   8      phase_decision[1:0], zero pad
// m_axis    out  24     fine_code[9:0], oscillator_code[17:10], zero pad
// cfg       in   16     write enable, 3-bit index, data
//
// one item per cycle while the result is not stalled: the accumulator add,
// clamp and proportional step sit combinationally between the input register and the result register.
// result valid is set when the item moves from the input register into the result register.
// reset loads the register defaults and the accumulator from the initial code.
// a stalled result holds the result register; the input register still
// takes one more item, then s_axis_tready drops until the result is taken.
module bang_bang_pll_loop_filter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // phase_decision[1:0]
  input  logic [bbpll_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // fine_code[9:0], oscillator_code[17:10]
  output logic [bbpll_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [bbpll_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [bbpll_pkg::CFG_W-1:0]      cfg_data_i
);
  import bbpll_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]  gain_q;
  logic [KP_W-1:0]    kp_q;
  logic [SHIFT_W-1:0] frac_q;
  logic [SHIFT_W-1:0] boost_q;
  logic [RUN_W-1:0]   blen_q;
  logic [SHIFT_W-1:0] decay_q;
  logic [INIT_W-1:0]  init_q;

  // loop state
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               dir_valid_q;
  logic               dir_up_q;
  logic [RUN_W-1:0]   run_q, run_d;

  // pipeline registers
  logic               s1_valid_q;
  logic [DEC_W-1:0]   s1_dec_q;
  logic               m_valid_q;
  logic [CODE_W-1:0]  code_q, code_d;

  logic               adv;
  logic               reload;
  logic [SHIFT_W-1:0] reload_frac;
  logic [INIT_W-1:0]  reload_init;
  logic [SHIFT_W-1:0] reload_frac_eff;
  logic [ACC_W-1:0]   reload_acc;

  logic [SHIFT_W-1:0] frac_eff;
  logic [ACC_W-1:0]   max_acc;
  logic               dec_up;
  logic               dec_hold;
  logic               same_dir;
  logic               reversal;
  logic               boost_en;
  logic [KI_W-1:0]    ki_boost;
  logic [KI_W-1:0]    ki_decay;
  logic [KI_W-1:0]    ki_eff;
  logic signed [SUM_W-1:0] sum;
  logic [ACC_W-1:0]   acc_old_shr;
  logic [ACC_W-1:0]   acc_new_shr;
  logic signed [CODE_W+1:0] code_s;

  // handshake
  assign adv           = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - CODE_W - OSC_W)'(0),
                          code_q[CODE_W-1:CODE_W-OSC_W], code_q};

  // reload value after a write to fraction bits or initial code
  assign reload = cfg_we_i && ((cfg_idx_i == REG_FRACTION_BITS) ||
                               (cfg_idx_i == REG_INITIAL_CODE));
  assign reload_frac = (cfg_idx_i == REG_FRACTION_BITS) ? cfg_data_i[SHIFT_W-1:0] : frac_q;
  assign reload_init = (cfg_idx_i == REG_INITIAL_CODE) ? cfg_data_i[INIT_W-1:0] : init_q;
  assign reload_frac_eff = (reload_frac > SHIFT_W'(MAX_FRACTION_BITS)) ?
                           SHIFT_W'(MAX_FRACTION_BITS) : reload_frac;
  assign reload_acc = ACC_W'({reload_init, 2'b00}) << reload_frac_eff;

  // decision decode and run tracking
  always_comb begin
    frac_eff = (frac_q > SHIFT_W'(MAX_FRACTION_BITS)) ? SHIFT_W'(MAX_FRACTION_BITS) : frac_q;
    max_acc  = ACC_W'(CODE_MAX) << frac_eff;
    dec_hold = (s1_dec_q == DEC_HOLD);
    dec_up   = (s1_dec_q == DEC_UP);
    same_dir = dir_valid_q && (dir_up_q == dec_up);
    reversal = dir_valid_q && !same_dir;
    if (same_dir) begin
      run_d = (run_q == RUN_MAX) ? RUN_MAX : run_q + RUN_W'(1);
    end else begin
      run_d = RUN_W'(1);
    end
    boost_en = (boost_q != '0) && (run_d >= blen_q);
  end

  // effective integral step
  always_comb begin
    ki_boost = KI_W'(gain_q) << boost_q;
    ki_decay = KI_W'(gain_q >> decay_q);
    if ((gain_q != '0) && (ki_decay == '0)) begin
      ki_decay = KI_W'(1);
    end
    if (boost_en) begin
      ki_eff = ki_boost;
    end else if ((decay_q != '0) && reversal) begin
      ki_eff = ki_decay;
    end else begin
      ki_eff = KI_W'(gain_q);
    end
  end

  // accumulator update with clamp
  always_comb begin
    if (dec_up) begin
      sum = $signed(SUM_W'(acc_q)) + $signed(SUM_W'(ki_eff));
    end else begin
      sum = $signed(SUM_W'(acc_q)) - $signed(SUM_W'(ki_eff));
    end
    if (sum < 0) begin
      acc_d = '0;
    end else if (sum > $signed(SUM_W'(max_acc))) begin
      acc_d = max_acc;
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  // proportional step and output clamp
  always_comb begin
    acc_old_shr = acc_q >> frac_eff;
    acc_new_shr = acc_d >> frac_eff;
    if (dec_up) begin
      code_s = $signed({2'b00, acc_new_shr[CODE_W-1:0]}) + $signed({2'b00, kp_q});
    end else begin
      code_s = $signed({2'b00, acc_new_shr[CODE_W-1:0]}) - $signed({2'b00, kp_q});
    end
    if (dec_hold) begin
      code_d = acc_old_shr[CODE_W-1:0];
    end else if (code_s < 0) begin
      code_d = '0;
    end else if (code_s > $signed({2'b00, CODE_MAX})) begin
      code_d = CODE_MAX;
    end else begin
      code_d = code_s[CODE_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= RST_INTEGRAL_GAIN;
      kp_q    <= RST_PROPORTIONAL_GAIN;
      frac_q  <= RST_FRACTION_BITS;
      boost_q <= RST_BOOST_SHIFT;
      blen_q  <= RST_BOOST_RUN_LENGTH;
      decay_q <= RST_DECAY_SHIFT;
      init_q  <= RST_INITIAL_CODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INTEGRAL_GAIN:     gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_PROPORTIONAL_GAIN: kp_q    <= cfg_data_i[KP_W-1:0];
        REG_FRACTION_BITS:     frac_q  <= cfg_data_i[SHIFT_W-1:0];
        REG_BOOST_SHIFT:       boost_q <= cfg_data_i[SHIFT_W-1:0];
        REG_BOOST_RUN_LENGTH:  blen_q  <= cfg_data_i[RUN_W-1:0];
        REG_DECAY_SHIFT:       decay_q <= cfg_data_i[SHIFT_W-1:0];
        REG_INITIAL_CODE:      init_q  <= cfg_data_i[INIT_W-1:0];
        default: ;
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= RST_ACC;
      dir_valid_q <= 1'b0;
      dir_up_q    <= 1'b0;
      run_q       <= '0;
    end else if (reload) begin
      acc_q       <= reload_acc;
      dir_valid_q <= 1'b0;
      dir_up_q    <= 1'b0;
      run_q       <= '0;
    end else if (adv && !dec_hold) begin
      acc_q       <= acc_d;
      dir_valid_q <= 1'b1;
      dir_up_q    <= dec_up;
      run_q       <= run_d;
    end
  end

  // input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_dec_q <= s_axis_tdata[DEC_W-1:0];
    end
    if (adv) begin
      code_q <= code_d;
    end
  end

endmodule

// ===== tb/bang_bang_pll_loop_filter_top_tb.sv =====
module bang_bang_pll_loop_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbpll_pkg::*;

  // down decisions: both patterns with the sign bit set
  localparam logic [DEC_W-1:0] DEC_DOWN     = 2'b11;
  localparam logic [DEC_W-1:0] DEC_DOWN_ALT = 2'b10;
  // index past the last register, writes are dropped
  localparam logic [IDX_W-1:0] REG_UNUSED   = 3'd7;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_COUNT  = 13;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CODE_W-1:0] fine;
    logic [OSC_W-1:0]  osc;
  } loop_codes_t;

  typedef struct packed {
    logic [DEC_W-1:0] decision;
    bit               drain_marker;
  } pending_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // phase_decision[1:0], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // fine_code[9:0], oscillator_code[17:10], zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [IDX_W-1:0]     cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  bang_bang_pll_loop_filter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // filter settings and state as the predictor sees them
  int unsigned cfg_ki, cfg_kp, cfg_frac, cfg_boost, cfg_boost_len, cfg_decay, cfg_init;
  longint      loop_acc;
  int          prev_dir;
  int unsigned same_dir_run;

  pending_item_t decision_queue[$];
  loop_codes_t   expected_codes[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  phase_no = 0;
  int  settings_count = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  drained_q = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_frac_bits();
    return (cfg_frac > MAX_FRACTION_BITS) ? MAX_FRACTION_BITS : cfg_frac;
  endfunction

  function automatic void restart_filter();
    loop_acc     = longint'(cfg_init * 4) << active_frac_bits();
    prev_dir     = 0;
    same_dir_run = 0;
  endfunction

  function automatic void model_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_INTEGRAL_GAIN:     cfg_ki = 32'(val[GAIN_W-1:0]);
      REG_PROPORTIONAL_GAIN: cfg_kp = 32'(val[KP_W-1:0]);
      REG_FRACTION_BITS: begin
        cfg_frac = 32'(val[SHIFT_W-1:0]);
        restart_filter();
      end
      REG_BOOST_SHIFT:       cfg_boost = 32'(val[SHIFT_W-1:0]);
      REG_BOOST_RUN_LENGTH:  cfg_boost_len = 32'(val[RUN_W-1:0]);
      REG_DECAY_SHIFT:       cfg_decay = 32'(val[SHIFT_W-1:0]);
      REG_INITIAL_CODE: begin
        cfg_init = 32'(val[INIT_W-1:0]);
        restart_filter();
      end
      default: ;
    endcase
  endfunction

  function automatic loop_codes_t next_loop_codes(logic [DEC_W-1:0] decision);
    int unsigned f;
    int          dir;
    bit          reversal;
    longint      ki_step;
    longint      acc_top;
    longint      code;
    loop_codes_t res;
    f = active_frac_bits();
    if (decision == DEC_HOLD) begin
      // hold: integral path only, direction tracking left alone
      code = loop_acc >>> f;
    end else begin
      dir      = (decision == DEC_UP) ? 1 : -1;
      reversal = (prev_dir != 0) && (dir != prev_dir);
      ki_step  = longint'(cfg_ki);
      acc_top  = longint'(CODE_MAX) << f;
      if (dir == prev_dir) begin
        if (same_dir_run < 32'(RUN_MAX)) same_dir_run++;
      end else begin
        prev_dir     = dir;
        same_dir_run = 1;
      end
      // boost wins over decay
      if (cfg_boost > 0 && same_dir_run >= cfg_boost_len) begin
        ki_step = longint'(cfg_ki) << cfg_boost;
      end else if (cfg_decay > 0 && reversal) begin
        ki_step = longint'(cfg_ki >> cfg_decay);
        if (cfg_ki > 0 && ki_step == 0) ki_step = 1;
      end
      loop_acc += (dir > 0) ? ki_step : -ki_step;
      if (loop_acc < 0) loop_acc = 0;
      if (loop_acc > acc_top) loop_acc = acc_top;
      code = (loop_acc >>> f) + ((dir > 0) ? longint'(cfg_kp) : -longint'(cfg_kp));
      if (code < 0) code = 0;
      if (code > longint'(CODE_MAX)) code = longint'(CODE_MAX);
    end
    res.fine = code[CODE_W-1:0];
    res.osc  = OSC_W'(code >> 2);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  // feed decisions from the pending queue, a drain marker holds off until idle
  always @(posedge clk_i or negedge rst_ni) begin : feeder
    bit offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      offer = 1'b0;
      if (decision_queue.size() != 0) begin
        if (decision_queue[0].drain_marker) begin
          if (!s_axis_tvalid && drained_q) void'(decision_queue.pop_front());
        end else begin
          offer = ($urandom_range(99) >= send_idle_pct);
        end
      end
      if (offer) begin
        s_axis_tdata <= S_TDATA_W'(decision_queue[0].decision);
        void'(decision_queue.pop_front());
      end
      s_axis_tvalid <= offer;
    end
  end

  // result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // check each result against the oldest expectation, predict on each accepted item
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    loop_codes_t want;
    if (!rst_ni) begin
      drained_q <= 1'b1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_codes.size() == 0) begin
          note_failure($sformatf("result %h with nothing expected", m_axis_tdata));
        end else begin
          want = expected_codes.pop_front();
          if (m_axis_tdata[CODE_W-1:0] !== want.fine)
            note_failure($sformatf("fine_code expected %0d got %0d", want.fine,
                                   m_axis_tdata[CODE_W-1:0]));
          if (m_axis_tdata[CODE_W+OSC_W-1:CODE_W] !== want.osc)
            note_failure($sformatf("oscillator_code expected %0d got %0d", want.osc,
                                   m_axis_tdata[CODE_W+OSC_W-1:CODE_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        expected_codes.insert(expected_codes.size(),
                              next_loop_codes(s_axis_tdata[DEC_W-1:0]));
      end
      drained_q <= (expected_codes.size() == 0);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_decision(input logic [DEC_W-1:0] d);
    pending_item_t it;
    it.decision     = d;
    it.drain_marker = 1'b0;
    decision_queue.insert(decision_queue.size(), it);
  endtask

  task automatic push_drain();
    pending_item_t it;
    it.decision     = DEC_HOLD;
    it.drain_marker = 1'b1;
    decision_queue.insert(decision_queue.size(), it);
  endtask

  function automatic logic [DEC_W-1:0] any_down();
    return $urandom_range(1) ? DEC_DOWN : DEC_DOWN_ALT;
  endfunction

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned usual);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r <= 4) return $urandom_range(hi, lo);
    return $urandom_range(usual, lo);
  endfunction

  // wait until nothing is pending or in flight, plus the pipeline depth
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (decision_queue.size() != 0 || s_axis_tvalid || expected_codes.size() != 0);
    repeat (4) @(posedge clk_i);
    #1;
  endtask

  // idling pattern by phase: sender light and receiver heavy, swapped, none
  task automatic start_phase();
    int mode;
    mode = phase_no * 3 / PHASE_COUNT;
    send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 55 : 0;
    recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 34 : 0;
    phase_no++;
  endtask

  task automatic program_filter(input int unsigned ki, kp, frac, boost, run_len, decay, init,
                                input bit poke_unused);
    logic [IDX_W-1:0] idx_list [7];
    logic [CFG_W-1:0] val_list [7];
    idx_list = '{REG_INTEGRAL_GAIN, REG_PROPORTIONAL_GAIN, REG_FRACTION_BITS,
                 REG_BOOST_SHIFT, REG_BOOST_RUN_LENGTH, REG_DECAY_SHIFT, REG_INITIAL_CODE};
    val_list = '{CFG_W'(ki), CFG_W'(kp), CFG_W'(frac), CFG_W'(boost), CFG_W'(run_len),
                 CFG_W'(decay), CFG_W'(init)};
    settings_count++;
    if (poke_unused) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_UNUSED;
      cfg_data_i <= CFG_W'($urandom());
    end
    for (int i = 0; i < 7; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
      model_write(idx_list[i], val_list[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    #1;
  endtask

  // runs, reversal trains, holds and noise with random content
  task automatic queue_mixed(input int n);
    int               target;
    int               len;
    int               kind;
    logic [DEC_W-1:0] d;
    target = decision_queue.size() + n;
    while (decision_queue.size() < target) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3, 4: begin
          len = $urandom_range(40, 1);
          d   = $urandom_range(1) ? DEC_UP : DEC_DOWN;
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) push_decision(DEC_HOLD);
            else push_decision((d == DEC_UP) ? DEC_UP : any_down());
          end
        end
        5, 6: begin
          len = $urandom_range(16, 2);
          d   = $urandom_range(1) ? DEC_UP : DEC_DOWN;
          for (int i = 0; i < len; i++) begin
            push_decision((d == DEC_UP) ? DEC_UP : any_down());
            d = (d == DEC_UP) ? DEC_DOWN : DEC_UP;
          end
        end
        7: begin
          len = $urandom_range(4, 1);
          for (int i = 0; i < len; i++) push_decision(DEC_HOLD);
        end
        default: begin
          len = $urandom_range(8, 1);
          for (int i = 0; i < len; i++) push_decision(DEC_W'($urandom_range(3)));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    cfg_ki        = 32'(RST_INTEGRAL_GAIN);
    cfg_kp        = 32'(RST_PROPORTIONAL_GAIN);
    cfg_frac      = 32'(RST_FRACTION_BITS);
    cfg_boost     = 32'(RST_BOOST_SHIFT);
    cfg_boost_len = 32'(RST_BOOST_RUN_LENGTH);
    cfg_decay     = 32'(RST_DECAY_SHIFT);
    cfg_init      = 32'(RST_INITIAL_CODE);
    restart_filter();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    #1;

    // reset settings: hold, both down patterns, reversals, a run of up decisions
    start_phase();
    settings_count++;
    push_decision(DEC_HOLD);
    push_decision(DEC_UP);
    push_decision(DEC_UP);
    push_decision(DEC_HOLD);
    push_decision(DEC_DOWN);
    push_decision(DEC_DOWN_ALT);
    push_decision(DEC_UP);
    push_decision(DEC_DOWN);
    push_decision(DEC_HOLD);
    for (int i = 0; i < 4; i++) push_decision(DEC_UP);
    push_decision(DEC_HOLD);
    wait_drained();

    // widest gains, oversize fraction, boost on every decision with decay armed
    program_filter(65535, 1023, 31, 20, 0, 31, 255, 1'b1);
    start_phase();
    push_decision(DEC_UP);
    push_decision(DEC_UP);
    push_decision(DEC_HOLD);
    push_decision(DEC_DOWN);
    push_decision(DEC_DOWN_ALT);
    push_decision(DEC_HOLD);
    push_decision(DEC_UP);
    wait_drained();

    // zero gain with decay armed, code pinned at the bottom
    program_filter(0, 0, 0, 0, 255, 3, 0, 1'b0);
    start_phase();
    push_decision(DEC_DOWN);
    push_decision(DEC_UP);
    push_decision(DEC_DOWN_ALT);
    push_decision(DEC_HOLD);
    push_decision(DEC_UP);
    wait_drained();

    // small gain decayed to nothing floors at one
    program_filter(3, 2, 0, 0, 255, 2, 0, 1'b0);
    start_phase();
    push_decision(DEC_UP);
    push_decision(DEC_DOWN);
    push_decision(DEC_UP);
    push_decision(DEC_DOWN_ALT);
    push_decision(DEC_HOLD);
    wait_drained();

    // random settings, one long run that saturates the run counter
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        program_filter(1, 3, 20, 8, 255, 2, 0, 1'b0);
        start_phase();
        for (int i = 0; i < 262; i++) begin
          if ($urandom_range(19) == 0) push_decision(DEC_HOLD);
          push_decision(DEC_UP);
        end
        for (int i = 0; i < 6; i++) push_decision(any_down());
        wait_drained();
      end
      program_filter(pick_value(0, 65535, 600), pick_value(0, 1023, 16),
                     pick_value(0, 31, 20), pick_value(0, 31, 4), pick_value(0, 255, 12),
                     pick_value(0, 31, 4), pick_value(0, 255, 255), $urandom_range(3) == 0);
      start_phase();
      queue_mixed(14);
      push_drain();
      queue_mixed(13);
      wait_drained();
    end

    if (expected_codes.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_codes.size());
    end
    $display("covered %0d phase decisions under %0d filter settings, %0d codes checked",
             items_taken, settings_count, results_seen);
    $display("runs, reversals, holds, clamps and stalls on both sides; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bbpll_pkg.sv
sv/bang_bang_pll_loop_filter_top.sv
tb/bang_bang_pll_loop_filter_top_tb.sv
